FILE: rtl/pbr_pkg.sv
// shared types, constants and helpers of the polynomial bisection root finder
`timescale 1ns / 1ps

package pbr_pkg;

	localparam int WORD_W          = 32;
	localparam int PROD_W          = 2 * WORD_W;
	localparam int NUM_COEFF       = 6;
	localparam int COEF_IDX_W      = 3;
	localparam int TOL_W           = 31;
	localparam int ITER_W          = 6;
	localparam int CFG_IDX_W       = 3;
	localparam int POLY_DEGREE_DEF = 5;
	localparam int FRAC_BITS_DEF   = 16;

	// reset values of the configuration registers
	localparam logic signed [WORD_W-1:0] COEFF_X1_RST = 32'sd65536;
	localparam logic [TOL_W-1:0]         TOL_RST      = 31'd66;
	localparam logic [ITER_W-1:0]        MAX_ITER_RST = 6'd32;

	typedef logic signed [WORD_W-1:0] word_t;

	// entry k multiplies x^k
	typedef word_t coeff_set_t [NUM_COEFF];

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_X5 = 3'd0,
		REG_COEFF_X4 = 3'd1,
		REG_COEFF_X3 = 3'd2,
		REG_COEFF_X2 = 3'd3,
		REG_COEFF_X1 = 3'd4,
		REG_COEFF_X0 = 3'd5,
		REG_TOL      = 3'd6,
		REG_MAX_ITER = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_TOL    = 2'd0,
		ST_LIMIT  = 2'd1,
		ST_NOSIGN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		XSEL_A,
		XSEL_B,
		XSEL_C
	} xsel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                  cap_in;
		logic                  ev_init;
		xsel_t                 xsel;
		logic                  ev_mul;
		logic                  ev_add;
		logic [COEF_IDX_W-1:0] coef_idx;
		logic                  save_fa;
		logic                  decide;
		logic                  fin;
		logic                  root_zero;
		status_t               fin_status;
	} dp_cmd_t;

	typedef struct packed {
		logic opp;
		logic in_tol;
	} dp_stat_t;

	// strictly opposite signs, zero counts as neither
	function automatic logic opposite(input word_t u, input word_t v);
		logic u_pos;
		logic v_pos;
		u_pos = !u[WORD_W-1] && (u != '0);
		v_pos = !v[WORD_W-1] && (v != '0);
		return (u[WORD_W-1] && v_pos) || (u_pos && v[WORD_W-1]);
	endfunction

endpackage

FILE: rtl/pbr_cfg.sv
// configuration register file: coefficients, tolerance and step limit
`timescale 1ns / 1ps

module pbr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbr_pkg::WORD_W-1:0]     cfg_data,
	output pbr_pkg::coeff_set_t            coeff,
	output logic [pbr_pkg::TOL_W-1:0]      tol,
	output logic [pbr_pkg::ITER_W-1:0]     max_iter
);

	pbr_pkg::coeff_set_t               coeff_q;
	logic [pbr_pkg::TOL_W-1:0]         tol_q;
	logic [pbr_pkg::ITER_W-1:0]        max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// all coefficients clear except the linear term, which resets to one
			for (int k = 0; k < pbr_pkg::NUM_COEFF; k++) begin
				coeff_q[k] <= (k == 1) ? pbr_pkg::COEFF_X1_RST : '0;
			end
			tol_q      <= pbr_pkg::TOL_RST;
			max_iter_q <= pbr_pkg::MAX_ITER_RST;
		end else if (cfg_write) begin
			unique case (pbr_pkg::cfg_reg_t'(cfg_index))
				pbr_pkg::REG_COEFF_X5: coeff_q[5] <= $signed(cfg_data);
				pbr_pkg::REG_COEFF_X4: coeff_q[4] <= $signed(cfg_data);
				pbr_pkg::REG_COEFF_X3: coeff_q[3] <= $signed(cfg_data);
				pbr_pkg::REG_COEFF_X2: coeff_q[2] <= $signed(cfg_data);
				pbr_pkg::REG_COEFF_X1: coeff_q[1] <= $signed(cfg_data);
				pbr_pkg::REG_COEFF_X0: coeff_q[0] <= $signed(cfg_data);
				pbr_pkg::REG_TOL:      tol_q      <= cfg_data[pbr_pkg::TOL_W-1:0];
				pbr_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[pbr_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	assign coeff    = coeff_q;
	assign tol      = tol_q;
	assign max_iter = max_iter_q;

endmodule

FILE: rtl/pbr_dp.sv
// datapath: interval ends, shared horner multiply-add unit and result registers
`timescale 1ns / 1ps

module pbr_dp #(
	parameter int POLY_DEGREE = pbr_pkg::POLY_DEGREE_DEF,
	parameter int FRAC_BITS   = pbr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pbr_pkg::dp_cmd_t             cmd,
	output pbr_pkg::dp_stat_t            stat,
	input  pbr_pkg::word_t               lower_end,
	input  pbr_pkg::word_t               upper_end,
	input  pbr_pkg::coeff_set_t          coeff,
	input  logic [pbr_pkg::TOL_W-1:0]    tol,
	output pbr_pkg::word_t               root,
	output pbr_pkg::status_t             status,
	output logic                         done
);

	localparam int W = pbr_pkg::WORD_W;

	pbr_pkg::word_t             a_q;
	pbr_pkg::word_t             b_q;
	pbr_pkg::word_t             x_q;
	pbr_pkg::word_t             acc_q;
	pbr_pkg::word_t             fa_q;
	logic signed [pbr_pkg::PROD_W-1:0] prod_q;
	pbr_pkg::word_t             root_q;
	pbr_pkg::status_t           status_q;
	logic                       done_q;

	logic signed [pbr_pkg::PROD_W-1:0] prod_sh;
	pbr_pkg::word_t             prod_sat;
	logic signed [W:0]          add_sum;
	pbr_pkg::word_t             add_sat;
	logic signed [W:0]          end_sum;
	pbr_pkg::word_t             mid;
	logic [W-1:0]               mag;
	pbr_pkg::word_t             x_next;

	// floor of the product to the fraction grid, clamp to the word, then add the coefficient and clamp again
	always_comb begin
		prod_sh = prod_q >>> FRAC_BITS;
		if (&prod_sh[pbr_pkg::PROD_W-1:W-1] || ~|prod_sh[pbr_pkg::PROD_W-1:W-1]) begin
			prod_sat = prod_sh[W-1:0];
		end else if (prod_sh[pbr_pkg::PROD_W-1]) begin
			prod_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			prod_sat = {1'b0, {(W-1){1'b1}}};
		end
		add_sum = {prod_sat[W-1], prod_sat} + {coeff[cmd.coef_idx][W-1], coeff[cmd.coef_idx]};
		if (add_sum[W] == add_sum[W-1]) begin
			add_sat = add_sum[W-1:0];
		end else if (add_sum[W]) begin
			add_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			add_sat = {1'b0, {(W-1){1'b1}}};
		end
	end

	// floor of the halved sum
	assign end_sum = {a_q[W-1], a_q} + {b_q[W-1], b_q};
	assign mid     = end_sum[W:1];

	always_comb begin
		case (cmd.xsel)
			pbr_pkg::XSEL_A: x_next = a_q;
			pbr_pkg::XSEL_B: x_next = b_q;
			default:         x_next = mid;
		endcase
	end

	assign mag         = acc_q[W-1] ? (~acc_q + 1'b1) : acc_q;
	assign stat.in_tol = mag < {1'b0, tol};
	assign stat.opp    = pbr_pkg::opposite(fa_q, acc_q);

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			a_q <= lower_end;
			b_q <= upper_end;
		end
		if (cmd.ev_init) begin
			x_q   <= x_next;
			acc_q <= coeff[POLY_DEGREE];
		end
		if (cmd.ev_mul) begin
			prod_q <= acc_q * x_q;
		end
		if (cmd.ev_add) begin
			acc_q <= add_sat;
		end
		if (cmd.save_fa) begin
			fa_q <= acc_q;
		end
		if (cmd.decide) begin
			if (stat.opp) begin
				b_q <= x_q;
			end else begin
				a_q  <= x_q;
				fa_q <= acc_q;
			end
		end
		if (cmd.fin) begin
			root_q   <= cmd.root_zero ? '0 : x_q;
			status_q <= cmd.fin_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	assign root   = root_q;
	assign status = status_q;
	assign done   = done_q;

endmodule

FILE: rtl/pbr_ctrl.sv
// controller: sequences horner steps, endpoint checks and bisection steps
`timescale 1ns / 1ps

module pbr_ctrl #(
	parameter int POLY_DEGREE = pbr_pkg::POLY_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pbr_pkg::ITER_W-1:0]    max_iter,
	input  pbr_pkg::dp_stat_t             stat,
	output pbr_pkg::dp_cmd_t              cmd
);

	localparam int KW = pbr_pkg::COEF_IDX_W;
	localparam int IW = pbr_pkg::ITER_W;

	pbr_pkg::state_t  state_q, state_d;
	pbr_pkg::xsel_t   tgt_q, tgt_d;
	logic [KW-1:0]    k_q, k_d;
	logic [IW-1:0]    iter_q, iter_d;
	logic [IW-1:0]    iter_inc;

	assign iter_inc = iter_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbr_pkg::S_IDLE;
			tgt_q   <= pbr_pkg::XSEL_A;
			k_q     <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			tgt_q   <= tgt_d;
			k_q     <= k_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		tgt_d          = tgt_q;
		k_d            = k_q;
		iter_d         = iter_q;
		cmd.cap_in     = 1'b0;
		cmd.ev_init    = 1'b0;
		cmd.xsel       = tgt_q;
		cmd.ev_mul     = 1'b0;
		cmd.ev_add     = 1'b0;
		cmd.coef_idx   = k_q;
		cmd.save_fa    = 1'b0;
		cmd.decide     = 1'b0;
		cmd.fin        = 1'b0;
		cmd.root_zero  = 1'b0;
		cmd.fin_status = pbr_pkg::ST_TOL;

		unique case (state_q)
			pbr_pkg::S_IDLE: begin
				if (start) begin
					cmd.cap_in = 1'b1;
					tgt_d      = pbr_pkg::XSEL_A;
					state_d    = pbr_pkg::S_INIT;
				end
			end
			pbr_pkg::S_INIT: begin
				cmd.ev_init = 1'b1;
				k_d         = KW'(POLY_DEGREE - 1);
				state_d     = pbr_pkg::S_MUL;
			end
			pbr_pkg::S_MUL: begin
				cmd.ev_mul = 1'b1;
				state_d    = pbr_pkg::S_ADD;
			end
			pbr_pkg::S_ADD: begin
				cmd.ev_add = 1'b1;
				if (k_q == '0) begin
					state_d = pbr_pkg::S_DONE;
				end else begin
					k_d     = k_q - 1'b1;
					state_d = pbr_pkg::S_MUL;
				end
			end
			pbr_pkg::S_DONE: begin
				case (tgt_q)
					pbr_pkg::XSEL_A: begin
						cmd.save_fa = 1'b1;
						tgt_d       = pbr_pkg::XSEL_B;
						state_d     = pbr_pkg::S_INIT;
					end
					pbr_pkg::XSEL_B: begin
						if (!stat.opp) begin
							cmd.fin        = 1'b1;
							cmd.root_zero  = 1'b1;
							cmd.fin_status = pbr_pkg::ST_NOSIGN;
							state_d        = pbr_pkg::S_IDLE;
						end else if (max_iter == '0) begin
							cmd.fin        = 1'b1;
							cmd.root_zero  = 1'b1;
							cmd.fin_status = pbr_pkg::ST_LIMIT;
							state_d        = pbr_pkg::S_IDLE;
						end else begin
							iter_d  = '0;
							tgt_d   = pbr_pkg::XSEL_C;
							state_d = pbr_pkg::S_INIT;
						end
					end
					default: begin
						if (stat.in_tol) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = pbr_pkg::ST_TOL;
							state_d        = pbr_pkg::S_IDLE;
						end else begin
							cmd.decide = 1'b1;
							if (iter_inc == max_iter) begin
								cmd.fin        = 1'b1;
								cmd.fin_status = pbr_pkg::ST_LIMIT;
								state_d        = pbr_pkg::S_IDLE;
							end else begin
								iter_d  = iter_inc;
								state_d = pbr_pkg::S_INIT;
							end
						end
					end
				endcase
			end
			default: state_d = pbr_pkg::S_IDLE;
		endcase
	end

	assign busy = (state_q != pbr_pkg::S_IDLE);

endmodule

FILE: rtl/polynomial_bisection_root.sv
// top level of the polynomial bisection root finder
`timescale 1ns / 1ps

// Finds a root of a configured polynomial (degree up to POLY_DEGREE, signed
// fixed point with FRAC_BITS fraction bits) inside [lower_end, upper_end] by
// bisection. An item is taken when start is high while busy is low; busy then
// stays high until the result is issued, and the result (root, status) is
// shown for exactly one cycle with done high. There is no backpressure: the
// result must be captured in that cycle. Every polynomial evaluation runs
// Horner's rule on one shared 32x32 multiplier: a load step, then per
// coefficient a multiply step and a floor/clamp/add/clamp step, then a
// decision step. An item evaluates both ends and then one midpoint per
// bisection step. Status 0 means the midpoint met the tolerance, 1 that
// max_iterations steps ran out (root is 0 when the limit is zero), 2 that
// the ends show no strict sign change (root is 0). Reversed ends are
// bisected the same way. Configuration writes take effect at once and
// must only be issued while busy is low.

module polynomial_bisection_root #(
	parameter int POLY_DEGREE = pbr_pkg::POLY_DEGREE_DEF,
	parameter int FRAC_BITS   = pbr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item handshake
	input  logic                           start,
	output logic                           busy,
	input  logic signed [31:0]             lower_end,
	input  logic signed [31:0]             upper_end,
	// result, valid for one cycle
	output logic                           done,
	output logic signed [31:0]             root,
	output logic [1:0]                     status,
	// configuration write port
	input  logic                           cfg_write,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbr_pkg::WORD_W-1:0]     cfg_data
);

	pbr_pkg::coeff_set_t             coeff;
	logic [pbr_pkg::TOL_W-1:0]       tol;
	logic [pbr_pkg::ITER_W-1:0]      max_iter;
	pbr_pkg::dp_cmd_t                cmd;
	pbr_pkg::dp_stat_t               stat;
	pbr_pkg::status_t                status_int;

	// coefficients, tolerance and step limit
	pbr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (coeff),
		.tol       (tol),
		.max_iter  (max_iter)
	);

	// sequencer: end evaluations, sign check, bisection steps
	pbr_ctrl #(
		.POLY_DEGREE (POLY_DEGREE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.max_iter (max_iter),
		.stat     (stat),
		.cmd      (cmd)
	);

	// interval registers, horner unit and result registers
	pbr_dp #(
		.POLY_DEGREE (POLY_DEGREE),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.lower_end (lower_end),
		.upper_end (upper_end),
		.coeff     (coeff),
		.tol       (tol),
		.root      (root),
		.status    (status_int),
		.done      (done)
	);

	assign status = status_int;

	// the result strobe comes with the return to idle, never during work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the end of an item always produces its result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	// an accepted item keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start work");

	// a rejected interval reports a zero root
	a_nosign_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == pbr_pkg::ST_NOSIGN)) |-> (root == '0))
		else $error("no sign change with nonzero root");

endmodule
